/* sv/tsu_pkg.sv */
// tsu_pkg: shared types and constants of the taylor sigmoid unit
// no dependencies
package tsu_pkg;

  localparam int X_W    = 16;
  localparam int T_W    = 17;
  localparam int B_W    = 38;
  localparam int P_W    = B_W + T_W;
  localparam int D_W    = 37;
  localparam int N_W    = 42;
  localparam int Q_W    = 17;
  localparam int R_W    = 16;
  localparam int STEPS  = 8;
  localparam int FRAC_B = 24;

  localparam logic signed [B_W-1:0] ONE_Q24 = B_W'(64'sd16777216);
  localparam logic signed [P_W-1:0] RND_HALF = P_W'(64'sd2048);

  typedef struct packed {
    logic signed [X_W-1:0] x_value;
    logic                  last_in;
  } tsu_in_t;

  typedef struct packed {
    logic [R_W-1:0] sigmoid_value;
    logic           last_out;
  } tsu_out_t;

  typedef struct packed {
    logic signed [B_W-1:0] b;
    logic                  last;
  } tsu_acc_t;

  typedef struct packed {
    logic [Q_W-1:0] q;
    logic           sat;
    logic           last;
  } tsu_quo_t;

  function automatic logic signed [B_W-1:0] coef_q24(input int k);
    logic signed [B_W-1:0] c;
    case (k)
      0:       c = B_W'(64'sd416);
      1:       c = B_W'(64'sd3329);
      2:       c = B_W'(64'sd23302);
      3:       c = B_W'(64'sd139810);
      4:       c = B_W'(64'sd699051);
      5:       c = B_W'(64'sd2796203);
      6:       c = B_W'(64'sd8388608);
      7:       c = B_W'(64'sd16777216);
      8:       c = B_W'(64'sd16777216);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* sv/tsu_horner.sv */
// tsu_horner: pipelined horner evaluation of the degree-8 exp polynomial of -x
// depends on tsu_pkg
module tsu_horner (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  tsu_pkg::tsu_in_t in_i,
  output logic             valid_o,
  output tsu_pkg::tsu_acc_t acc_o
);
  import tsu_pkg::*;

  logic [STEPS:0]        vld_q;
  logic signed [T_W-1:0] t_q    [0:STEPS];
  logic signed [B_W-1:0] b_q    [0:STEPS];
  logic                  last_q [0:STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STEPS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q[0]    <= -T_W'(in_i.x_value);
      b_q[0]    <= coef_q24(0);
      last_q[0] <= in_i.last_in;
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic signed [P_W-1:0] prod;
    logic signed [P_W-1:0] rnd;
    logic signed [B_W-1:0] b_d;
    assign prod = P_W'(b_q[k-1]) * P_W'(t_q[k-1]);
    assign rnd  = (prod + RND_HALF) >>> 12;
    assign b_d  = B_W'(rnd) + coef_q24(k);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q[k]    <= t_q[k-1];
        b_q[k]    <= b_d;
        last_q[k] <= last_q[k-1];
      end
    end
  end

  assign valid_o   = vld_q[STEPS];
  assign acc_o.b   = b_q[STEPS];
  assign acc_o.last = last_q[STEPS];

  a_poly_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[STEPS] |-> (b_q[STEPS] > -ONE_Q24))
    else $error("polynomial left positive range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(vld_q))
    else $error("pipeline moved while held");

endmodule

/* sv/tsu_div.sv */
// tsu_div: pipelined restoring division forming the rounded quotient 2^40 / (2^24 + p), one bit per stage
// depends on tsu_pkg
module tsu_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  tsu_pkg::tsu_acc_t acc_i,
  output logic              valid_o,
  output tsu_pkg::tsu_quo_t quo_o
);
  import tsu_pkg::*;

  logic [Q_W:0]      vld_q;
  logic [D_W-1:0]    d_q    [0:Q_W];
  logic [D_W-1:0]    rem_q  [0:Q_W];
  logic [Q_W-1:0]    nlo_q  [0:Q_W];
  logic [Q_W-1:0]    q_q    [0:Q_W];
  logic              sat_q  [0:Q_W];
  logic              last_q [0:Q_W];

  logic [D_W-1:0] d_d;
  logic [N_W-1:0] n_d;

  assign d_d = D_W'(acc_i.b + ONE_Q24);
  assign n_d = (N_W'(1) << (FRAC_B + R_W)) + N_W'(d_d >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Q_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0]    <= d_d;
      rem_q[0]  <= D_W'(n_d >> Q_W);
      nlo_q[0]  <= n_d[Q_W-1:0];
      q_q[0]    <= '0;
      sat_q[0]  <= (acc_i.b <= B_W'(0));
      last_q[0] <= acc_i.last;
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_bit
    logic [D_W:0]   trial;
    logic           fits;
    logic [D_W-1:0] rem_d;
    assign trial = {rem_q[j], nlo_q[j][Q_W-1-j]};
    assign fits  = (trial >= {1'b0, d_q[j]});
    assign rem_d = fits ? D_W'(trial - {1'b0, d_q[j]}) : D_W'(trial);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[j+1]    <= d_q[j];
        rem_q[j+1]  <= rem_d;
        nlo_q[j+1]  <= nlo_q[j];
        q_q[j+1]    <= {q_q[j][Q_W-2:0], fits};
        sat_q[j+1]  <= sat_q[j];
        last_q[j+1] <= last_q[j];
      end
    end
  end

  assign valid_o    = vld_q[Q_W];
  assign quo_o.q    = q_q[Q_W];
  assign quo_o.sat  = sat_q[Q_W];
  assign quo_o.last = last_q[Q_W];

  a_rem_lt_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Q_W] && !sat_q[Q_W] |-> (rem_q[Q_W] < d_q[Q_W]))
    else $error("remainder not below divisor");

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Q_W] && !sat_q[Q_W] |-> (q_q[Q_W] <= Q_W'(65536)))
    else $error("quotient out of range");

endmodule

/* sv/taylor_sigmoid_unit_top.sv */
// taylor_sigmoid_unit_top: sigmoid via degree-8 taylor exp and pipelined divide
// depends on tsu_pkg, tsu_horner, tsu_div
//
//  channel   direction  handshake                   payload
//  request   in         in_valid_i / in_stall_o     in_data_i  (tsu_in_t)
//  result    out        out_valid_o / out_stall_i   out_data_o (tsu_out_t)
//
// one request per cycle while the result is not stalled; 9 horner stages (input register,
// then eight with one multiplier each) and 18 divider stages (operand setup,
// then one quotient bit each)
// reset clears only the stage valid bits
// a stalled result freezes the whole pipeline; nothing is dropped or repeated
module taylor_sigmoid_unit_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tsu_pkg::tsu_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tsu_pkg::tsu_out_t out_data_o
);
  import tsu_pkg::*;

  logic     en;
  logic     acc_valid;
  tsu_acc_t acc;
  tsu_quo_t quo;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  tsu_horner u_horner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .in_i    (in_data_i),
    .valid_o (acc_valid),
    .acc_o   (acc)
  );

  tsu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (acc_valid),
    .acc_i   (acc),
    .valid_o (out_valid_o),
    .quo_o   (quo)
  );

  assign out_data_o.sigmoid_value = (quo.sat || quo.q[Q_W-1]) ? '1 : quo.q[R_W-1:0];
  assign out_data_o.last_out      = quo.last;

  a_sat_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && quo.sat |-> (out_data_o.sigmoid_value == '1))
    else $error("saturated result not full scale");

endmodule

/* test/taylor_sigmoid_unit_top_tb.sv */
// taylor_sigmoid_unit_top_tb: self-checking bench for the taylor sigmoid unit
// drives directed and random samples, predicts 1/(1+taylor_exp(-x)) per sample
// depends on tsu_pkg and taylor_sigmoid_unit_top
module taylor_sigmoid_unit_top_tb;
  import tsu_pkg::*;

  localparam int  RAND_ITEMS = 1250;
  localparam int  DRAIN_CYC  = 60;
  localparam longint LIMIT   = 400000;

  class sigmoid_scoreboard;
    tsu_out_t pending[$];
    int       checked;

    function tsu_out_t predict(tsu_in_t req);
      longint t, b, d, q;
      tsu_out_t r;
      longint coefs[9] = '{416, 3329, 23302, 139810, 699051, 2796203,
                           8388608, 16777216, 16777216};
      t = -longint'(req.x_value);
      b = coefs[0];
      for (int k = 1; k < 9; k++) b = ((b * t + 2048) >>> 12) + coefs[k];
      d = 64'sd16777216 + b;
      if (d <= 0) q = 65535;
      else begin
        q = ((64'sd1 << 40) + (d >>> 1)) / d;
        if (q > 65535) q = 65535;
      end
      r.sigmoid_value = q[15:0];
      r.last_out = req.last_in;
      return r;
    endfunction

    function void note_request(tsu_in_t req);
      pending.push_back(predict(req));
    endfunction

    // empty string means the result matched
    function string check_result(tsu_out_t got);
      tsu_out_t exp_r;
      checked++;
      if (pending.size() == 0) return $sformatf("unexpected result %p", got);
      exp_r = pending.pop_front();
      if (got.sigmoid_value !== exp_r.sigmoid_value)
        return $sformatf("sigmoid_value got %0d want %0d", got.sigmoid_value,
                         exp_r.sigmoid_value);
      if (got.last_out !== exp_r.last_out)
        return $sformatf("last_out got %0b want %0b", got.last_out, exp_r.last_out);
      return "";
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  tsu_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  tsu_out_t out_data_o;

  sigmoid_scoreboard sb = new();
  int     errors = 0;
  int     sent = 0;
  int     lasts_sent = 0;
  longint cycles = 0;
  int     stall_mode = 0;

  taylor_sigmoid_unit_top dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      msg = sb.check_result(out_data_o);
      if (msg != "") report(msg);
    end
  end

  // receiver stall pattern, switching between free, light and heavy
  always @(negedge clk_i) begin
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 9) < 3);
      default: out_stall_i <= ($urandom_range(0, 9) < 7);
    endcase
  end

  task automatic send(input logic signed [15:0] x, input logic lst);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= '{x_value: x, last_in: lst};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request('{x_value: x, last_in: lst});
    sent++;
    if (lst) lasts_sent++;
  endtask

  task automatic idle(input int n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    for (int i = 1; i < n; i++) @(negedge clk_i);
  endtask

  initial begin
    logic signed [15:0] directed[$] = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd1,
      -16'sd1, 16'sd4096, -16'sd4096, 16'sd8192, -16'sd8192, 16'sd2048,
      -16'sd2048, 16'sd16384, -16'sd16384, 16'sd24576, -16'sd24576,
      16'sh5555, 16'shAAAA, 16'sd12, -16'sd12, 16'sd32000, -16'sd32000};
    int burst;
    logic signed [15:0] x;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[i]) send(directed[i], i[0]);
    idle(3);
    while (sent < directed.size() + RAND_ITEMS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        case ($urandom_range(0, 3))
          0:       x = 16'($urandom);
          1:       x = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
          2:       x = $signed(16'($urandom_range(0, 24575))) - 16'sd12288;
          default: x = $urandom_range(0, 1) ? 16'sh8000 + 16'($urandom_range(0, 63))
                                            : 16'sh7FFF - 16'($urandom_range(0, 63));
        endcase
        send(x, $urandom_range(0, 7) == 0);
      end
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
    end
    idle(1);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    $display("sent %0d samples (%0d marked last), checked %0d results",
             sent, lasts_sent, sb.checked);
    $display("covered full-range, near-zero and extreme samples under random stalls");
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
